// File: rtl/wal_pkg.sv
// Shared types and constants for the write-ahead log controller.
// No dependencies; imported by every module of the block.
package wal_pkg;

  localparam int LOG_CAPACITY = 30;
  localparam int MAX_ENTRIES  = 29;
  localparam int IDX_W        = $clog2(LOG_CAPACITY);
  // a log-write is refused once entry_count reaches this
  localparam int FULL_LIMIT   = (LOG_CAPACITY - 1 < MAX_ENTRIES) ? LOG_CAPACITY - 1
                                                                 : MAX_ENTRIES;
  localparam int CFG_ADDR_W   = 4;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_END    = 2'd1,
    OP_WRITE  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_GRANTED   = 4'd0,
    ST_WAIT      = 4'd1,
    ST_ENDED     = 4'd2,
    ST_ABSORBED  = 4'd3,
    ST_APPENDED  = 4'd4,
    ST_TOO_BIG   = 4'd5,
    ST_OUTSIDE   = 4'd6,
    ST_END_NO_BG = 4'd7,
    ST_COMMIT    = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_COPY   = 2'd1,
    CMD_HEADER = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    PIN_NONE  = 2'd0,
    PIN_PIN   = 2'd1,
    PIN_UNPIN = 2'd2
  } pin_t;

  typedef enum logic [1:0] {
    REG_LOG_START = 2'd0,
    REG_LOG_SIZE  = 2'd1,
    REG_DEVICE    = 2'd2,
    REG_BPO       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] block_number;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  command;
    logic [7:0]  device;
    logic [31:0] source_block;
    logic [31:0] destination_block;
    logic [4:0]  header_count;
    logic [1:0]  pin_change;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] log_start_block;
    logic [4:0]  log_size_blocks;
    logic [7:0]  device_number;
    logic [4:0]  blocks_per_operation;
  } cfg_regs_t;

  // control from the sequencer to the row of entry cells
  typedef struct packed {
    logic             rotate;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_data;
  } ring_ctl_t;

endpackage

// File: rtl/write_ahead_log_controller.sv
// Write-ahead log controller with group commit. Begin, end and log-write
// beats enter on in_*; result beats leave on out_*, the final one of each
// item flagged by last. Begin, end and rejected log-writes get a single
// result beat. A log-write that reaches the table is looked up in it: the
// logged block numbers sit in a ring of LOG_CAPACITY cells that turns once
// past a single comparator, then the block is absorbed or appended. The end
// that closes the last open operation with n entries emits 2n+2 commit
// beats: copy-out beats turn the ring, idle turns bring it back into line,
// then the header, copy-home beats with unpin, and the zero header. One
// item is in work at a time; the result register lets the next item enter
// in the cycle its last beat is taken. No clearing pass follows reset:
// table entries are only read below the entry count. Registers sit on an
// APB-style port at byte addresses 4*i.
// Depends on wal_pkg, wal_cell, wal_cfg and wal_ctrl.
module write_ahead_log_controller
  import wal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_regs_t   cfg;
  ring_ctl_t   ring_ctl;
  logic [31:0] entries [LOG_CAPACITY];

  wal_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ring of entries: on rotate each cell takes its upper neighbor, the top
  // cell wraps to cell 0, so cell 0 walks through the table in order
  for (genvar i = 0; i < LOG_CAPACITY; i++) begin : g_cell
    wal_cell u_cell (
      .clk        (clk),
      .ring_ctl   (ring_ctl),
      .cell_idx   (IDX_W'(i)),
      .next_entry (entries[(i + 1) % LOG_CAPACITY]),
      .entry      (entries[i])
    );
  end

  wal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .head_entry (entries[0]),
    .ring_ctl   (ring_ctl)
  );

endmodule

// File: rtl/wal_cell.sv
// One entry of the logged-block table; part of a rotating ring of cells.
// Depends on wal_pkg.
module wal_cell
  import wal_pkg::*;
(
  input  logic             clk,
  input  ring_ctl_t        ring_ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [31:0]      next_entry,
  output logic [31:0]      entry
);

  logic [31:0] entry_r;

  // rotate: take the neighbor's entry; otherwise accept an append
  always_ff @(posedge clk) begin
    if (ring_ctl.rotate) begin
      entry_r <= next_entry;
    end else if (ring_ctl.wr_en && (ring_ctl.wr_idx == cell_idx)) begin
      entry_r <= ring_ctl.wr_data;
    end
  end

  assign entry = entry_r;

endmodule

// File: rtl/wal_cfg.sv
// APB-style configuration registers of the log controller.
// Depends on wal_pkg.
module wal_cfg
  import wal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r;
  reg_idx_t  sel;

  assign sel    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_start_block      <= '0;
      cfg_r.log_size_blocks      <= 5'd30;
      cfg_r.device_number        <= '0;
      cfg_r.blocks_per_operation <= 5'd5;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_LOG_START: cfg_r.log_start_block      <= pwdata;
        REG_LOG_SIZE:  cfg_r.log_size_blocks      <= pwdata[4:0];
        REG_DEVICE:    cfg_r.device_number        <= pwdata[7:0];
        REG_BPO:       cfg_r.blocks_per_operation <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_LOG_START: prdata = cfg_r.log_start_block;
      REG_LOG_SIZE:  prdata = {27'd0, cfg_r.log_size_blocks};
      REG_DEVICE:    prdata = {24'd0, cfg_r.device_number};
      REG_BPO:       prdata = {27'd0, cfg_r.blocks_per_operation};
    endcase
  end

endmodule

// File: rtl/wal_ctrl.sv
// Sequencer: admission, table search, commit run and the result register.
// Depends on wal_pkg; drives the ring of wal_cell entries.
module wal_ctrl
  import wal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_regs_t   cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic [31:0] head_entry,
  output ring_ctl_t   ring_ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SRESULT, S_COPY_OUT, S_REALIGN, S_HDR, S_COPY_HOME, S_ZHDR
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       open_r, open_nxt;
  logic [4:0]       count_r, count_nxt;
  logic             commit_r, commit_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             hit_r, hit_nxt;
  logic [31:0]      blk_r, blk_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  logic             load_ok;
  logic             accept;
  logic [IDX_W-1:0] pos_inc;
  logic             pos_at_end;
  logic             pos_is_last_entry;
  logic [13:0]      reserve;
  logic [14:0]      need;
  logic             too_big;
  out_beat_t        beat;

  assign load_ok  = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !load_ok;
  assign accept   = in_valid && !in_stall;

  assign pos_at_end        = (pos_r == IDX_W'(LOG_CAPACITY - 1));
  assign pos_inc           = pos_at_end ? '0 : pos_r + 1'b1;
  assign pos_is_last_entry = (32'(pos_r) + 32'd1 == 32'(count_r));

  assign reserve = 14'({1'b0, open_r} + 9'd1) * 14'(cfg.blocks_per_operation);
  assign need    = 15'(reserve) + 15'(count_r);
  assign too_big = (count_r >= cfg.log_size_blocks) || (32'(count_r) >= FULL_LIMIT);

  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    count_nxt     = count_r;
    commit_nxt    = commit_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ring_ctl      = '0;
    ring_ctl.wr_idx  = IDX_W'(count_r);
    ring_ctl.wr_data = blk_r;
    beat          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          beat.last = 1'b1;
          unique case (opcode_t'(in_data.opcode))
            OP_BEGIN: begin
              if (commit_r || open_r == 8'hFF || need > 15'(cfg.log_size_blocks)) begin
                beat.status = ST_WAIT;
              end else begin
                beat.status = ST_GRANTED;
                open_nxt    = open_r + 8'd1;
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = beat;
            end
            OP_END: begin
              if (open_r == 8'd0) begin
                beat.status   = ST_END_NO_BG;
                out_valid_nxt = 1'b1;
                out_data_nxt  = beat;
              end else begin
                open_nxt = open_r - 8'd1;
                if (open_r == 8'd1 && count_r != 5'd0) begin
                  commit_nxt = 1'b1;
                  pos_nxt    = '0;
                  state_nxt  = S_COPY_OUT;
                end else begin
                  beat.status   = ST_ENDED;
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = beat;
                end
              end
            end
            OP_WRITE: begin
              if (too_big) begin
                beat.status   = ST_TOO_BIG;
                out_valid_nxt = 1'b1;
                out_data_nxt  = beat;
              end else if (open_r == 8'd0) begin
                beat.status   = ST_OUTSIDE;
                out_valid_nxt = 1'b1;
                out_data_nxt  = beat;
              end else begin
                blk_nxt   = in_data.block_number;
                hit_nxt   = 1'b0;
                pos_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            OP_UNUSED: ;
          endcase
        end
      end

      // one full turn of the ring; cell 0 holds original entry pos_r
      S_SEARCH: begin
        ring_ctl.rotate = 1'b1;
        hit_nxt = hit_r || ((32'(pos_r) < 32'(count_r)) && (head_entry == blk_r));
        pos_nxt = pos_inc;
        if (pos_at_end) begin
          state_nxt = S_SRESULT;
        end
      end

      S_SRESULT: begin
        if (load_ok) begin
          beat.last = 1'b1;
          if (hit_r) begin
            beat.status = ST_ABSORBED;
          end else begin
            beat.status     = ST_APPENDED;
            beat.pin_change = PIN_PIN;
            ring_ctl.wr_en  = 1'b1;
            count_nxt       = count_r + 5'd1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = beat;
          state_nxt     = S_IDLE;
        end
      end

      S_COPY_OUT: begin
        if (load_ok) begin
          beat.status            = ST_COMMIT;
          beat.command           = CMD_COPY;
          beat.device            = cfg.device_number;
          beat.source_block      = head_entry;
          beat.destination_block = cfg.log_start_block + 32'(pos_r) + 32'd1;
          out_valid_nxt   = 1'b1;
          out_data_nxt    = beat;
          ring_ctl.rotate = 1'b1;
          pos_nxt         = pos_inc;
          if (pos_is_last_entry) begin
            state_nxt = pos_at_end ? S_HDR : S_REALIGN;
          end
        end
      end

      // finish the turn so entry 0 is back at cell 0
      S_REALIGN: begin
        ring_ctl.rotate = 1'b1;
        pos_nxt         = pos_inc;
        if (pos_at_end) begin
          state_nxt = S_HDR;
        end
      end

      S_HDR: begin
        if (load_ok) begin
          beat.status            = ST_COMMIT;
          beat.command           = CMD_HEADER;
          beat.device            = cfg.device_number;
          beat.destination_block = cfg.log_start_block;
          beat.header_count      = count_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = beat;
          state_nxt     = S_COPY_HOME;
        end
      end

      S_COPY_HOME: begin
        if (load_ok) begin
          beat.status            = ST_COMMIT;
          beat.command           = CMD_COPY;
          beat.device            = cfg.device_number;
          beat.source_block      = cfg.log_start_block + 32'(pos_r) + 32'd1;
          beat.destination_block = head_entry;
          beat.pin_change        = PIN_UNPIN;
          out_valid_nxt   = 1'b1;
          out_data_nxt    = beat;
          ring_ctl.rotate = 1'b1;
          pos_nxt         = pos_inc;
          if (pos_is_last_entry) begin
            state_nxt = S_ZHDR;
          end
        end
      end

      S_ZHDR: begin
        if (load_ok) begin
          beat.status            = ST_COMMIT;
          beat.command           = CMD_HEADER;
          beat.device            = cfg.device_number;
          beat.destination_block = cfg.log_start_block;
          beat.last              = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = beat;
          count_nxt     = 5'd0;
          commit_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      count_r     <= '0;
      commit_r    <= 1'b0;
      pos_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      count_r     <= count_nxt;
      commit_r    <= commit_nxt;
      pos_r       <= pos_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
